// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion wrappers shared by the commutation block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SSC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// types, widths and sector helpers of the six-step commutation block
// ----------------------------------------------------------------------------
package ssc_pkg;

   localparam int PWM_W   = 15;
   localparam int MS_W    = 16;
   localparam int KICKS_W = 8;
   localparam int HALL_W  = 3;
   localparam int POS_W   = 32;
   localparam int TIME_W  = 32;
   localparam int VOLT_W  = 16;
   localparam int PHASE_W = 2;
   localparam int DUTY_W  = 16;

   // 19 * pwm_full_scale fits in five more bits
   localparam int P19_W = PWM_W + 5;
   // pwm_full_scale * |target| stays below 2^30
   localparam int NUM_W = PWM_W + VOLT_W - 1;
   localparam int LIM_W = P19_W + VOLT_W;
   localparam int MAG_W = PWM_W;
   localparam int REM_W = VOLT_W;
   localparam int CNT_W = 4;

   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(VOLT_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);

   localparam logic [VOLT_W-1:0] CLAMP_DIVISOR = VOLT_W'(20);

   localparam int FWD_PROGRESS_COUNTS = 6;
   localparam logic signed [POS_W:0] FAR_AHEAD  = (POS_W + 1)'(FWD_PROGRESS_COUNTS);
   localparam logic signed [POS_W:0] FAR_BEHIND = -FAR_AHEAD;

   localparam logic [HALL_W-1:0] HALL_LAST = HALL_W'(5);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [2:0] {
      FAULT_NONE   = 3'd0,
      FAULT_STALL  = 3'd1,
      FAULT_CMD    = 3'd2,
      FAULT_HALL   = 3'd3,
      FAULT_SUPPLY = 3'd4
   } fault_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PWM_FULL  = 3'd0,
      CSR_KICK_MS   = 3'd1,
      CSR_IDLE_MS   = 3'd2,
      CSR_MAX_KICKS = 3'd3,
      CSR_HALL_INV  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PWM_W-1:0]   pwm_full;
      logic [MS_W-1:0]    kick_ms;
      logic [MS_W-1:0]    idle_ms;
      logic [KICKS_W-1:0] max_kicks;
      logic               hall_inv;
   } cfg_type;

   typedef struct packed {
      logic [HALL_W-1:0]        hall;
      logic signed [POS_W-1:0]  pos;
      logic [TIME_W-1:0]        now;
      logic signed [VOLT_W-1:0] tgt;
      logic                     tbad;
      logic [VOLT_W-1:0]        bus;
      logic                     bbad;
      logic                     on;
   } item_type;

   typedef struct packed {
      logic                     drive_active;
      logic [PHASE_W-1:0]       phase_high;
      logic [PHASE_W-1:0]       phase_low;
      logic signed [DUTY_W-1:0] duty;
      fault_type                fault_code;
      logic                     kick_active;
   } result_type;

   typedef struct packed {
      fault_type fault;
      logic      kicking;
      logic      early;
   } status_type;

   // sectors AB,AC,BC,BA,CA,CB
   function automatic logic [PHASE_W-1:0] sector_high(input logic [HALL_W-1:0] s);
      logic [PHASE_W-1:0] ph;
      unique case (s)
         3'd0, 3'd1: ph = 2'd0;
         3'd2, 3'd3: ph = 2'd1;
         3'd4, 3'd5: ph = 2'd2;
         default:    ph = 2'd0;
      endcase
      return ph;
   endfunction

   function automatic logic [PHASE_W-1:0] sector_low(input logic [HALL_W-1:0] s);
      logic [PHASE_W-1:0] ph;
      unique case (s)
         3'd0, 3'd5: ph = 2'd1;
         3'd1, 3'd2: ph = 2'd2;
         3'd3, 3'd4: ph = 2'd0;
         default:    ph = 2'd0;
      endcase
      return ph;
   endfunction

   function automatic logic [HALL_W-1:0] sector_step(input logic [HALL_W-1:0] s,
                                                     input logic back);
      logic [HALL_W-1:0] nxt;
      if (back) begin
         nxt = (s == '0) ? HALL_LAST : s - HALL_W'(1);
      end else begin
         nxt = (s == HALL_LAST) ? '0 : s + HALL_W'(1);
      end
      return nxt;
   endfunction

endpackage

// File: hdl/ssc_mul.sv
// ----------------------------------------------------------------------------
// ssc_mul
// two bit-serial shift-add multipliers: duty numerator and clamp limit
// ----------------------------------------------------------------------------
module ssc_mul import ssc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [PWM_W-1:0]   num_a,
   input  logic [VOLT_W-1:0]  num_b,
   input  logic [P19_W-1:0]   lim_a,
   input  logic [VOLT_W-1:0]  lim_b,
   output logic               done,
   output logic [NUM_W-1:0]   num,
   output logic [LIM_W-1:0]   lim
);

   logic              run_ff, run_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  num_a_ff, num_a_in, num_acc_ff, num_acc_in;
   logic [VOLT_W-1:0] num_b_ff, num_b_in, lim_b_ff, lim_b_in;
   logic [LIM_W-1:0]  lim_a_ff, lim_a_in, lim_acc_ff, lim_acc_in;

   assign done = run_ff && (cnt_ff == MUL_LAST);
   assign num  = num_acc_ff;
   assign lim  = lim_acc_ff;

   always_comb begin
      run_in     = run_ff;
      cnt_in     = cnt_ff;
      num_a_in   = num_a_ff;
      num_b_in   = num_b_ff;
      num_acc_in = num_acc_ff;
      lim_a_in   = lim_a_ff;
      lim_b_in   = lim_b_ff;
      lim_acc_in = lim_acc_ff;
      if (start) begin
         run_in     = 1'b1;
         cnt_in     = '0;
         num_a_in   = NUM_W'(num_a);
         num_b_in   = num_b;
         num_acc_in = '0;
         lim_a_in   = LIM_W'(lim_a);
         lim_b_in   = lim_b;
         lim_acc_in = '0;
      end else if (run_ff) begin
         // one multiplier bit per cycle, lsb first
         if (num_b_ff[0]) num_acc_in = num_acc_ff + num_a_ff;
         if (lim_b_ff[0]) lim_acc_in = lim_acc_ff + lim_a_ff;
         num_a_in = num_a_ff << 1;
         lim_a_in = lim_a_ff << 1;
         num_b_in = num_b_ff >> 1;
         lim_b_in = lim_b_ff >> 1;
         cnt_in   = cnt_ff + CNT_W'(1);
         if (cnt_ff == MUL_LAST) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_a_ff   <= num_a_in;
      num_b_ff   <= num_b_in;
      num_acc_ff <= num_acc_in;
      lim_a_ff   <= lim_a_in;
      lim_b_ff   <= lim_b_in;
      lim_acc_ff <= lim_acc_in;
   end

endmodule

// File: hdl/ssc_div.sv
// ----------------------------------------------------------------------------
// ssc_div
// restoring divider, one quotient bit per cycle, round to nearest even
// ----------------------------------------------------------------------------
module ssc_div import ssc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  dividend,
   input  logic [VOLT_W-1:0] divisor,
   output logic              done,
   output logic [MAG_W-1:0]  mag
);

   logic              run_ff, run_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  dq_ff, dq_in;
   logic [VOLT_W-1:0] div_ff, div_in;
   logic [REM_W:0]    shifted;
   logic [REM_W+1:0]  diff;
   logic              fits;
   logic [REM_W:0]    twice_rem;
   logic [REM_W:0]    div_wide;
   logic              round_up;

   // quotient bits shift into dq while the low dividend bits shift out
   assign shifted = {rem_ff, dq_ff[MAG_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, div_ff};
   assign fits    = !diff[REM_W+1];

   assign twice_rem = {rem_ff, 1'b0};
   assign div_wide  = {1'b0, div_ff};
   assign round_up  = (twice_rem > div_wide) || ((twice_rem == div_wide) && dq_ff[0]);
   assign mag       = dq_ff + MAG_W'(round_up);
   assign done      = run_ff && (cnt_ff == DIV_LAST);

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dq_in  = dq_ff;
      div_in = div_ff;
      if (start) begin
         // the high part is already below the divisor
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = REM_W'(dividend[NUM_W-1:MAG_W]);
         dq_in  = dividend[MAG_W-1:0];
         div_in = divisor;
      end else if (run_ff) begin
         rem_in = fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
         dq_in  = {dq_ff[MAG_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == DIV_LAST) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      div_ff <= div_in;
   end

endmodule

// File: hdl/ssc_recovery.sv
// ----------------------------------------------------------------------------
// ssc_recovery
// fault priority, progress watchdog, kick sequencing and result forming
// ----------------------------------------------------------------------------
module ssc_recovery import ssc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  item_type         item,
   input  logic             flags_load,
   input  logic             commit,
   input  logic [MAG_W-1:0] mag,
   output result_type       result,
   output status_type       status
);

   fault_type               fault_ff, fault_in;
   dir_type                 dir_ff, dir_in;
   logic [KICKS_W-1:0]      kick_count_ff, kick_count_in;
   logic                    kicking_ff, kicking_in;
   logic signed [POS_W-1:0] prog_pos_ff, prog_pos_in;
   logic signed [POS_W-1:0] origin_ff, origin_in;
   logic [TIME_W-1:0]       prog_time_ff, prog_time_in;
   logic [TIME_W-1:0]       kick_time_ff, kick_time_in;
   logic [HALL_W-1:0]       kick_sector_ff, kick_sector_in;

   logic dir_change_ff, gain_ff, far_ff, kick_due_ff, idle_due_ff;

   logic                    tgt_neg, off, hall_bad, bus_bad;
   dir_type                 dir_cmd;
   logic                    dir_change_c, gain_c, far_c, kick_due_c, idle_due_c;
   logic signed [POS_W:0]   origin_diff;
   logic [TIME_W-1:0]       kick_age, idle_age;
   logic                    kick_held, kick_end, still_kicking, time_reset;
   logic                    fire, stall, kick_now, duty_neg;
   logic [KICKS_W-1:0]      count_base;
   logic [HALL_W-1:0]       new_sector, out_sector;
   logic signed [DUTY_W-1:0] duty;

   assign tgt_neg  = item.tgt[VOLT_W-1];
   assign dir_cmd  = tgt_neg ? DIR_REV : DIR_FWD;
   assign off      = !item.on || (!item.tbad && (item.tgt == '0));
   assign hall_bad = item.hall > HALL_LAST;
   assign bus_bad  = item.bbad || (item.bus == '0);

   assign status.early   = off || (fault_ff == FAULT_STALL) || item.tbad || hall_bad || bus_bad;
   assign status.fault   = fault_ff;
   assign status.kicking = kicking_ff;

   // watchdog compares against the state before this tick
   assign dir_change_c = dir_cmd != dir_ff;
   assign gain_c       = !dir_change_c &&
                         (tgt_neg ? (item.pos < prog_pos_ff) : (item.pos > prog_pos_ff));
   assign origin_diff  = {item.pos[POS_W-1], item.pos} - {origin_ff[POS_W-1], origin_ff};
   assign far_c        = tgt_neg ? (origin_diff <= FAR_BEHIND) : (origin_diff >= FAR_AHEAD);
   assign kick_age     = item.now - kick_time_ff;
   assign idle_age     = item.now - prog_time_ff;
   assign kick_due_c   = kick_age >= TIME_W'(cfg.kick_ms);
   assign idle_due_c   = idle_age >= TIME_W'(cfg.idle_ms);

   always_ff @(posedge clock) begin
      if (flags_load) begin
         dir_change_ff <= dir_change_c;
         gain_ff       <= gain_c;
         far_ff        <= far_c;
         kick_due_ff   <= kick_due_c;
         idle_due_ff   <= idle_due_c;
      end
   end

   // kick decision
   assign kick_held     = kicking_ff && !dir_change_ff && !gain_ff;
   assign kick_end      = kick_held && kick_due_ff;
   assign still_kicking = kick_held && !kick_due_ff;
   assign time_reset    = dir_change_ff || gain_ff || kick_end;
   assign fire          = !still_kicking &&
                          (time_reset ? (cfg.idle_ms == '0) : idle_due_ff);
   assign count_base    = (gain_ff && far_ff) ? '0 : kick_count_ff;
   assign stall         = fire && (count_base >= cfg.max_kicks);
   assign kick_now      = fire && !stall;
   assign duty_neg      = tgt_neg ^ cfg.hall_inv;
   assign new_sector    = sector_step(item.hall, duty_neg);
   assign out_sector    = kick_now ? new_sector : (still_kicking ? kick_sector_ff : item.hall);
   assign duty          = duty_neg ? (DUTY_W'(0) - DUTY_W'(mag)) : DUTY_W'(mag);

   always_comb begin
      fault_in       = fault_ff;
      dir_in         = dir_ff;
      kick_count_in  = kick_count_ff;
      kicking_in     = kicking_ff;
      prog_pos_in    = prog_pos_ff;
      origin_in      = origin_ff;
      prog_time_in   = prog_time_ff;
      kick_time_in   = kick_time_ff;
      kick_sector_in = kick_sector_ff;
      result         = '0;
      priority if (off) begin
         fault_in      = FAULT_NONE;
         dir_in        = DIR_NONE;
         kick_count_in = '0;
         kicking_in    = 1'b0;
      end else if (fault_ff == FAULT_STALL) begin
         fault_in = FAULT_STALL;
      end else if (item.tbad) begin
         fault_in   = FAULT_CMD;
         kicking_in = 1'b0;
      end else if (hall_bad) begin
         fault_in   = FAULT_HALL;
         kicking_in = 1'b0;
      end else if (bus_bad) begin
         fault_in   = FAULT_SUPPLY;
         kicking_in = 1'b0;
      end else if (mag == '0) begin
         fault_in   = FAULT_NONE;
         kicking_in = 1'b0;
      end else begin
         fault_in      = FAULT_NONE;
         dir_in        = dir_cmd;
         kicking_in    = still_kicking;
         kick_count_in = count_base;
         if (dir_change_ff || gain_ff) prog_pos_in = item.pos;
         if (dir_change_ff) origin_in = item.pos;
         if (time_reset) prog_time_in = item.now;
         if (stall) begin
            fault_in = FAULT_STALL;
         end else begin
            if (fire) begin
               kick_count_in  = count_base + KICKS_W'(1);
               kicking_in     = 1'b1;
               kick_time_in   = item.now;
               origin_in      = item.pos;
               kick_sector_in = new_sector;
            end
            result.drive_active = 1'b1;
            result.phase_high   = sector_high(out_sector);
            result.phase_low    = sector_low(out_sector);
            result.duty         = duty;
            result.kick_active  = kicking_in;
         end
      end
      result.fault_code = fault_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff       <= FAULT_NONE;
         dir_ff         <= DIR_NONE;
         kick_count_ff  <= '0;
         kicking_ff     <= 1'b0;
         prog_pos_ff    <= '0;
         origin_ff      <= '0;
         prog_time_ff   <= '0;
         kick_time_ff   <= '0;
         kick_sector_ff <= '0;
      end else if (commit) begin
         fault_ff       <= fault_in;
         dir_ff         <= dir_in;
         kick_count_ff  <= kick_count_in;
         kicking_ff     <= kicking_in;
         prog_pos_ff    <= prog_pos_in;
         origin_ff      <= origin_in;
         prog_time_ff   <= prog_time_in;
         kick_time_ff   <= kick_time_in;
         kick_sector_ff <= kick_sector_in;
      end
   end

endmodule

// File: hdl/six_step_commutation_stall_recovery_top.sv
// ----------------------------------------------------------------------------
// six_step_commutation_stall_recovery_top
// six-step commutation with duty normalization and stall recovery kicks
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | contents
//  req_     | in        | req_valid/ready   | one control tick (hall, position, time, volts)
//  rsp_     | out       | rsp_valid/ready   | driven phases, signed duty, fault, kick flag
//  csr_     | in        | csr_we            | register write, index and data, no read-back
//
//  a driving tick steps through classify, bit-serial multiply, clamp compare, divide,
//  round and commit
//  ticks that coast early (off, stall latched, bad command, hall or supply) go from classify straight to commit
//  reset is synchronous; it clears control and recovery state and loads register defaults
//  the result register frees the input side: a new transfer is taken while a result waits,
//  and only the commit step stalls until the result register is taken
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module six_step_commutation_stall_recovery_top import ssc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // tick input
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [HALL_W-1:0]        req_hall_sector,
   input  logic signed [POS_W-1:0]  req_position_count,
   input  logic [TIME_W-1:0]        req_time_ms,
   input  logic signed [VOLT_W-1:0] req_target_volts,
   input  logic                     req_target_bad,
   input  logic [VOLT_W-1:0]        req_bus_volts,
   input  logic                     req_bus_bad,
   input  logic                     req_drive_on,
   // result output
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_drive_active,
   output logic [PHASE_W-1:0]       rsp_phase_high,
   output logic [PHASE_W-1:0]       rsp_phase_low,
   output logic signed [DUTY_W-1:0] rsp_duty,
   output logic [2:0]               rsp_fault_code,
   output logic                     rsp_kick_active,
   // register writes
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_PREP   = 7'b0000010,
      S_MUL    = 7'b0000100,
      S_CMP    = 7'b0001000,
      S_DIV    = 7'b0010000,
      S_ROUND  = 7'b0100000,
      S_FINISH = 7'b1000000
   } fsm_type;

   fsm_type    state_ff, state_in;
   cfg_type    cfg_ff, cfg_in;
   item_type   item_ff, item_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0] mag_ff, mag_in;

   logic              req_xfer, out_free, commit;
   logic [P19_W-1:0]  p19;
   logic [VOLT_W-1:0] tgt_mag;
   logic              mul_start, mul_done, div_start, div_done;
   logic [NUM_W-1:0]  num;
   logic [LIM_W-1:0]  lim, num20;
   logic              clamp;
   logic [NUM_W-1:0]  dividend;
   logic [VOLT_W-1:0] divisor;
   logic [MAG_W-1:0]  div_mag;
   result_type        rec_result;
   status_type        rec_status;

   assign req_ready = state_ff == S_IDLE;
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == S_FINISH) && out_free;

   // 19p = 16p + 2p + p, the 95% ceiling numerator
   assign p19 = (P19_W'(cfg_ff.pwm_full) << 4) + (P19_W'(cfg_ff.pwm_full) << 1)
              + P19_W'(cfg_ff.pwm_full);

   // magnitude of the signed target, full negative value included
   assign tgt_mag = item_ff.tgt[VOLT_W-1] ? (VOLT_W'(0) - item_ff.tgt) : item_ff.tgt;

   // clamp when p*|t|*20 reaches 19p*bus
   assign num20 = (LIM_W'(num) << 4) + (LIM_W'(num) << 2);
   assign clamp = num20 >= lim;

   assign mul_start = (state_ff == S_PREP) && !rec_status.early;
   assign div_start = state_ff == S_CMP;
   assign dividend  = clamp ? NUM_W'(p19) : num;
   assign divisor   = clamp ? CLAMP_DIVISOR : item_ff.bus;

   ssc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .num_a (cfg_ff.pwm_full),
      .num_b (tgt_mag),
      .lim_a (p19),
      .lim_b (item_ff.bus),
      .done  (mul_done),
      .num   (num),
      .lim   (lim)
   );

   ssc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .mag      (div_mag)
   );

   ssc_recovery u_recovery (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (item_ff),
      .flags_load (state_ff == S_PREP),
      .commit     (commit),
      .mag        (mag_ff),
      .result     (rec_result),
      .status     (rec_status)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_PREP;
         S_PREP:   state_in = rec_status.early ? S_FINISH : S_MUL;
         S_MUL:    if (mul_done) state_in = S_CMP;
         S_CMP:    state_in = S_DIV;
         S_DIV:    if (div_done) state_in = S_ROUND;
         S_ROUND:  state_in = S_FINISH;
         S_FINISH: if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // tick capture
   always_comb begin
      item_in = item_ff;
      if (req_xfer) begin
         item_in.hall = req_hall_sector;
         item_in.pos  = req_position_count;
         item_in.now  = req_time_ms;
         item_in.tgt  = req_target_volts;
         item_in.tbad = req_target_bad;
         item_in.bus  = req_bus_volts;
         item_in.bbad = req_bus_bad;
         item_in.on   = req_drive_on;
      end
   end

   assign mag_in = (state_ff == S_ROUND) ? div_mag : mag_ff;

   // register writes, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PWM_FULL:  cfg_in.pwm_full  = csr_wdata[PWM_W-1:0];
            CSR_KICK_MS:   cfg_in.kick_ms   = csr_wdata[MS_W-1:0];
            CSR_IDLE_MS:   cfg_in.idle_ms   = csr_wdata[MS_W-1:0];
            CSR_MAX_KICKS: cfg_in.max_kicks = csr_wdata[KICKS_W-1:0];
            CSR_HALL_INV:  cfg_in.hall_inv  = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_in       = rec_result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         rsp_valid_ff       <= 1'b0;
         cfg_ff.pwm_full    <= PWM_W'(1000);
         cfg_ff.kick_ms     <= MS_W'(50);
         cfg_ff.idle_ms     <= MS_W'(200);
         cfg_ff.max_kicks   <= KICKS_W'(3);
         cfg_ff.hall_inv    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      mag_ff  <= mag_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_active = rsp_ff.drive_active;
   assign rsp_phase_high   = rsp_ff.phase_high;
   assign rsp_phase_low    = rsp_ff.phase_low;
   assign rsp_duty         = rsp_ff.duty;
   assign rsp_fault_code   = rsp_ff.fault_code;
   assign rsp_kick_active  = rsp_ff.kick_active;

   // coast results carry nothing but the fault code
   `SSC_ASSERT_IMPLIES(a_coast_quiet, clock, reset, rsp_valid_ff && !rsp_ff.drive_active, rsp_ff.duty == '0 && !rsp_ff.kick_active && rsp_ff.phase_high == '0 && rsp_ff.phase_low == '0, "coast result with drive fields set")

   // a driving result has no fault, a nonzero duty and two distinct phases
   `SSC_ASSERT_IMPLIES(a_drive_clean, clock, reset, rsp_valid_ff && rsp_ff.drive_active, rsp_ff.fault_code == FAULT_NONE && rsp_ff.duty != '0 && rsp_ff.phase_high != rsp_ff.phase_low, "inconsistent drive result")

   // a latched stall never coexists with a kick in force
   `SSC_ASSERT_IMPLIES(a_stall_no_kick, clock, reset, rec_status.fault == FAULT_STALL, !rec_status.kicking, "kick active under stall fault")

   // a new result only appears out of the commit step
   `SSC_ASSERT_IMPLIES(a_result_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_FINISH), "result without commit")

   // one tick in flight at a time
   `SSC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "second transfer taken while busy")

endmodule
